FILE: src/matrix_vector_transform_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector transform core
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_CORE_ASSERT_SVH
`define MATRIX_VECTOR_TRANSFORM_CORE_ASSERT_SVH

// Same-cycle implication
`define MVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the matrix-vector transform core.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int LANES     = 4;
    localparam int ELEMS     = LANES * LANES;
    localparam int IDX_W     = $clog2(ELEMS);
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;

    typedef logic signed [WORD_W-1:0] mvt_word_t;

    // One in fixed point
    localparam mvt_word_t ONE_Q = mvt_word_t'(1) <<< FRAC_BITS;
    localparam mvt_word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam mvt_word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_VEC4  = 2'd1,
        OP_POINT = 2'd2
    } mvt_opcode_t;

    // Stage enables for the lanes
    typedef struct packed {
        logic load;
        logic mul_en;
        logic sum_en;
    } mvt_lane_ctrl_t;

    // Output stage control
    typedef struct packed {
        logic load;
        logic point;
    } mvt_merge_ctrl_t;

    typedef struct packed {
        mvt_word_t value;
        logic      sat;
    } mvt_lane_res_t;

endpackage

FILE: src/mvt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_cmd_if / mvt_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface mvt_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [3:0]        elem_index;
    mvt_pkg::mvt_word_t elem_value;
    mvt_pkg::mvt_word_t vec_x;
    mvt_pkg::mvt_word_t vec_y;
    mvt_pkg::mvt_word_t vec_z;
    mvt_pkg::mvt_word_t vec_w;

    modport source (output valid, opcode, elem_index, elem_value,
                    vec_x, vec_y, vec_z, vec_w, input ready);
    modport sink   (input valid, opcode, elem_index, elem_value,
                    vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

interface mvt_res_if;
    logic              valid;
    logic              ready;
    mvt_pkg::mvt_word_t out_x;
    mvt_pkg::mvt_word_t out_y;
    mvt_pkg::mvt_word_t out_z;
    mvt_pkg::mvt_word_t out_w;
    logic              saturated;

    modport source (output valid, out_x, out_y, out_z, out_w, saturated,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, saturated,
                    output ready);
endinterface

FILE: src/mvt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_lane
// One dot-product lane: operand latch, four products, pair sums, then the
// final add with floor shift and saturation.
// ----------------------------------------------------------------------------
module mvt_lane
(
    input  logic                   clk,
    input  mvt_pkg::mvt_lane_ctrl_t ctrl,
    input  mvt_pkg::mvt_word_t     m_row [mvt_pkg::LANES],
    input  mvt_pkg::mvt_word_t     vec   [mvt_pkg::LANES],
    output mvt_pkg::mvt_lane_res_t res
);

    localparam int LO = mvt_pkg::FRAC_BITS;
    localparam int HI = mvt_pkg::FRAC_BITS + mvt_pkg::WORD_W - 1;

    mvt_pkg::mvt_word_t                 m_reg    [mvt_pkg::LANES];
    mvt_pkg::mvt_word_t                 v_reg    [mvt_pkg::LANES];
    logic signed [mvt_pkg::PROD_W-1:0]  prod_reg [mvt_pkg::LANES];
    logic signed [mvt_pkg::PAIR_W-1:0]  pair_reg [2];
    logic signed [mvt_pkg::SUM_W-1:0]   total;
    logic [mvt_pkg::SUM_W-1:HI]         top_bits;
    logic                               ovf;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            m_reg <= m_row;
            v_reg <= vec;
        end
        if (ctrl.mul_en)
        begin
            for (int k = 0; k < mvt_pkg::LANES; k++)
            begin
                prod_reg[k] <= mvt_pkg::PROD_W'(m_reg[k]) * mvt_pkg::PROD_W'(v_reg[k]);
            end
        end
        if (ctrl.sum_en)
        begin
            pair_reg[0] <= mvt_pkg::PAIR_W'(prod_reg[0]) + mvt_pkg::PAIR_W'(prod_reg[1]);
            pair_reg[1] <= mvt_pkg::PAIR_W'(prod_reg[2]) + mvt_pkg::PAIR_W'(prod_reg[3]);
        end
    end

    // exact sum; the floor shift is a bit-select, clip when the top bits disagree
    always_comb
    begin
        total    = mvt_pkg::SUM_W'(pair_reg[0]) + mvt_pkg::SUM_W'(pair_reg[1]);
        top_bits = total[mvt_pkg::SUM_W-1:HI];
        ovf      = !((&top_bits) || !(|top_bits));
        res.sat  = ovf;
        if (!ovf)
        begin
            res.value = total[HI:LO];
        end
        else if (total[mvt_pkg::SUM_W-1])
        begin
            res.value = mvt_pkg::WORD_MIN;
        end
        else
        begin
            res.value = mvt_pkg::WORD_MAX;
        end
    end

endmodule

FILE: src/mvt_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_merge
// Output register: gathers the four lane results and the clip flag.
// ----------------------------------------------------------------------------
module mvt_merge
(
    input  logic                    clk,
    input  mvt_pkg::mvt_merge_ctrl_t ctrl,
    input  mvt_pkg::mvt_lane_res_t  lane_res [mvt_pkg::LANES],
    output mvt_pkg::mvt_word_t      out_x,
    output mvt_pkg::mvt_word_t      out_y,
    output mvt_pkg::mvt_word_t      out_z,
    output mvt_pkg::mvt_word_t      out_w,
    output logic                    saturated
);

    mvt_pkg::mvt_word_t x_reg, y_reg, z_reg, w_reg;
    logic               sat_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg   <= lane_res[0].value;
            y_reg   <= lane_res[1].value;
            z_reg   <= lane_res[2].value;
            // point mode reports no w and ignores its clip
            w_reg   <= ctrl.point ? '0 : lane_res[3].value;
            sat_reg <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat
                     | (lane_res[3].sat & !ctrl.point);
        end
    end

    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_w     = w_reg;
    assign saturated = sat_reg;

endmodule

FILE: src/matrix_vector_transform_core.sv
`timescale 1ns / 1ps
// Pipeline: a transform item passes through operand latch, multiply, pair add and
//   final add/clip into the output register. Matrix writes give no result.
// Throughput: one item per cycle unless a held result has filled every stage.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and loads the
//   identity matrix into the element store.
// ----------------------------------------------------------------------------
// matrix_vector_transform_core
// 4x4 fixed-point matrix times 4-vector with four parallel dot-product lanes.
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_core_assert.svh"

module matrix_vector_transform_core
(
    input  logic      clk,
    input  logic      rst_n,
    mvt_cmd_if.sink   cmd,
    mvt_res_if.source res
);

    // ------------------------------------------------------------------
    // Element store: sixteen words, column-major. Lane r reads the
    // fixed entries r, r+4, r+8, r+12, so no read port is needed.
    // ------------------------------------------------------------------
    mvt_pkg::mvt_word_t matrix_reg [mvt_pkg::ELEMS];

    // Pipeline occupancy and the point-mode tag that travels with each item
    logic a_v_reg, a_v_next, b_v_reg, b_v_next, c_v_reg, c_v_next;
    logic out_v_reg, out_v_next;
    logic a_pt_reg, a_pt_next, b_pt_reg, b_pt_next, c_pt_reg, c_pt_next;

    logic cmd_fire;
    logic is_write;
    logic is_xform;
    logic out_free, c_free, b_free, a_free;

    mvt_pkg::mvt_lane_ctrl_t  lane_ctrl;
    mvt_pkg::mvt_merge_ctrl_t merge_ctrl;
    mvt_pkg::mvt_word_t       vec [mvt_pkg::LANES];
    mvt_pkg::mvt_lane_res_t   lane_res [mvt_pkg::LANES];

    // ------------------------------------------------------------------
    // Handshake: each stage moves on when the stage after it is empty or
    // moving too, so bubbles collapse and a held result does not stop
    // new items until every stage is full.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_free = !out_v_reg || res.ready;
        c_free   = !c_v_reg || out_free;
        b_free   = !b_v_reg || c_free;
        a_free   = !a_v_reg || b_free;
    end

    assign cmd.ready = a_free;
    assign cmd_fire  = cmd.valid && a_free;
    assign is_write  = cmd.opcode == mvt_pkg::OP_WRITE;
    assign is_xform  = (cmd.opcode == mvt_pkg::OP_VEC4) || (cmd.opcode == mvt_pkg::OP_POINT);

    // Next state of the valid chain; the unused opcode is dropped here
    always_comb
    begin
        a_v_next   = a_free  ? (cmd_fire && is_xform) : a_v_reg;
        a_pt_next  = a_free  ? (cmd.opcode == mvt_pkg::OP_POINT) : a_pt_reg;
        b_v_next   = b_free  ? a_v_reg  : b_v_reg;
        b_pt_next  = b_free  ? a_pt_reg : b_pt_reg;
        c_v_next   = c_free  ? b_v_reg  : c_v_reg;
        c_pt_next  = c_free  ? b_pt_reg : c_pt_reg;
        out_v_next = out_free ? c_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
            a_pt_reg  <= 1'b0;
            b_pt_reg  <= 1'b0;
            c_pt_reg  <= 1'b0;
        end
        else
        begin
            a_v_reg   <= a_v_next;
            b_v_reg   <= b_v_next;
            c_v_reg   <= c_v_next;
            out_v_reg <= out_v_next;
            a_pt_reg  <= a_pt_next;
            b_pt_reg  <= b_pt_next;
            c_pt_reg  <= c_pt_next;
        end
    end

    // Element store: reset to identity, one element written per write item.
    // A transform accepted right after a write already sees the new value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int col = 0; col < mvt_pkg::LANES; col++)
            begin
                for (int row = 0; row < mvt_pkg::LANES; row++)
                begin
                    matrix_reg[col * mvt_pkg::LANES + row] <=
                        (col == row) ? mvt_pkg::ONE_Q : '0;
                end
            end
        end
        else if (cmd_fire && is_write)
        begin
            matrix_reg[cmd.elem_index] <= cmd.elem_value;
        end
    end

    // Stage enables shared by all lanes
    always_comb
    begin
        lane_ctrl.load   = cmd_fire && is_xform;
        lane_ctrl.mul_en = a_v_reg && b_free;
        lane_ctrl.sum_en = b_v_reg && c_free;
        merge_ctrl.load  = c_v_reg && out_free;
        merge_ctrl.point = c_pt_reg;
    end

    // Point mode replaces w with one
    always_comb
    begin
        vec[0] = cmd.vec_x;
        vec[1] = cmd.vec_y;
        vec[2] = cmd.vec_z;
        vec[3] = (cmd.opcode == mvt_pkg::OP_POINT) ? mvt_pkg::ONE_Q : cmd.vec_w;
    end

    // ------------------------------------------------------------------
    // Four lanes, one per result component
    // ------------------------------------------------------------------
    for (genvar r = 0; r < mvt_pkg::LANES; r++)
    begin : g_lane
        mvt_pkg::mvt_word_t m_row [mvt_pkg::LANES];

        for (genvar k = 0; k < mvt_pkg::LANES; k++)
        begin : g_tap
            assign m_row[k] = matrix_reg[r + mvt_pkg::LANES * k];
        end

        mvt_lane u_lane
        (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .m_row (m_row),
            .vec   (vec),
            .res   (lane_res[r])
        );
    end

    mvt_merge u_merge
    (
        .clk       (clk),
        .ctrl      (merge_ctrl),
        .lane_res  (lane_res),
        .out_x     (res.out_x),
        .out_y     (res.out_y),
        .out_z     (res.out_z),
        .out_w     (res.out_w),
        .saturated (res.saturated)
    );

    assign res.valid = out_v_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MVT_ASSERT_NOW(a_full_stall,
        out_v_reg && !res.ready && a_v_reg && b_v_reg && c_v_reg,
        !cmd.ready,
        "command taken while every stage is full and the result is held")

    `MVT_ASSERT_NEXT(a_no_entry_for_nontransform,
        cmd.valid && cmd.ready && cmd.opcode != mvt_pkg::OP_VEC4
            && cmd.opcode != mvt_pkg::OP_POINT,
        !a_v_reg,
        "write or unused opcode entered the pipeline")

    `MVT_ASSERT_NEXT(a_element_written,
        cmd.valid && cmd.ready && cmd.opcode == mvt_pkg::OP_WRITE,
        matrix_reg[$past(cmd.elem_index)] == $past(cmd.elem_value),
        "matrix element not updated by write item")

    `MVT_ASSERT_NOW(a_sat_means_clipped,
        res.valid && res.saturated,
        res.out_x == mvt_pkg::WORD_MAX || res.out_x == mvt_pkg::WORD_MIN
            || res.out_y == mvt_pkg::WORD_MAX || res.out_y == mvt_pkg::WORD_MIN
            || res.out_z == mvt_pkg::WORD_MAX || res.out_z == mvt_pkg::WORD_MIN
            || res.out_w == mvt_pkg::WORD_MAX || res.out_w == mvt_pkg::WORD_MIN,
        "saturation flagged with no component at a limit")

endmodule

FILE: tb/tb_matrix_vector_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_transform_core
// Self-checking bench for the 4x4 fixed-point matrix-vector transform core.
// A shadow copy of the element store predicts every transform item at the
// moment it is accepted. A monitor checks each result item against the oldest
// prediction. Bursty command traffic and a patterned result stall exercise the
// pipeline. Full matrix loads, partial updates, noise and drain-then-restart
// groups make up the random part.
// ----------------------------------------------------------------------------
module tb_matrix_vector_transform_core;
    import mvt_pkg::*;

    // Opcode that the core leaves unused and must ignore
    localparam logic [1:0] OP_SPARE      = 2'd3;
    localparam int         RANDOM_ITEMS  = 850;
    localparam int         SETTLE_CYCLES = 16;

    typedef struct {
        logic [1:0] opcode;
        logic [3:0] elem_index;
        mvt_word_t  elem_value;
        mvt_word_t  vec_x;
        mvt_word_t  vec_y;
        mvt_word_t  vec_z;
        mvt_word_t  vec_w;
        bit         drain_first;   // hold the item back until no result is outstanding
    } cmd_item_t;

    typedef struct {
        mvt_word_t x;
        mvt_word_t y;
        mvt_word_t z;
        mvt_word_t w;
        logic      sat;
    } vertex_res_t;

    logic clk = 1'b0;
    logic rst_n;

    mvt_cmd_if cmd_ch ();
    mvt_res_if res_ch ();

    matrix_vector_transform_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cmd_item_t   pending_cmds [$];
    vertex_res_t expected_vertices [$];
    mvt_word_t   matrix_shadow [ELEMS];
    cmd_item_t   cur_cmd;

    int fail_count = 0;
    int live_items = 0;
    int n_writes   = 0;
    int n_vec4     = 0;
    int n_point    = 0;
    int n_spare    = 0;
    int n_checked  = 0;
    int n_sat      = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // One lane: exact sum of four full products, floor shift, clip to 32 bits
    function automatic mvt_word_t lane_dot(input mvt_word_t col [LANES],
                                           input mvt_word_t vin [LANES],
                                           output logic clip);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] shifted;
        acc = '0;
        for (int k = 0; k < LANES; k++)
        begin
            a   = col[k];
            b   = vin[k];
            acc = acc + a * b;
        end
        shifted = acc >>> FRAC_BITS;
        clip    = 1'b0;
        if (shifted > WORD_MAX)
        begin
            clip = 1'b1;
            return WORD_MAX;
        end
        if (shifted < WORD_MIN)
        begin
            clip = 1'b1;
            return WORD_MIN;
        end
        return mvt_word_t'(shifted);
    endfunction

    // Whole vertex from the shadow store; point mode forces w to one and
    // drops lane 3 from both the output and the clip flag
    function automatic vertex_res_t transform_item(input cmd_item_t it);
        mvt_word_t   vin [LANES];
        mvt_word_t   col [LANES];
        mvt_word_t   lane_out [LANES];
        logic        clip;
        logic        any_clip;
        vertex_res_t r;
        vin = '{it.vec_x, it.vec_y, it.vec_z, (it.opcode == OP_POINT) ? ONE_Q : it.vec_w};
        any_clip = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            for (int k = 0; k < LANES; k++)
                col[k] = matrix_shadow[l + LANES * k];
            lane_out[l] = lane_dot(col, vin, clip);
            if (it.opcode == OP_POINT && l == LANES - 1)
            begin
                lane_out[l] = '0;
                clip        = 1'b0;
            end
            any_clip = any_clip | clip;
        end
        r.x   = lane_out[0];
        r.y   = lane_out[1];
        r.z   = lane_out[2];
        r.w   = lane_out[3];
        r.sat = any_clip;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_cmd(input logic [1:0] op, input logic [3:0] idx, input mvt_word_t val,
                           input mvt_word_t x, input mvt_word_t y, input mvt_word_t z,
                           input mvt_word_t w, input bit drain);
        cmd_item_t it;
        it.opcode      = op;
        it.elem_index  = idx;
        it.elem_value  = val;
        it.vec_x       = x;
        it.vec_y       = y;
        it.vec_z       = z;
        it.vec_w       = w;
        it.drain_first = drain;
        pending_cmds.push_back(it);
        if (op != OP_SPARE)
            live_items++;
    endtask

    // Mostly moderate values around +/- 2^scale, with extremes and raw words mixed in
    function automatic mvt_word_t pick_word(input int scale);
        case ($urandom_range(0, 11))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2, 3:    return mvt_word_t'($urandom);
            4:       return '0;
            5:       return ($urandom_range(0, 1) != 0) ? ONE_Q : -ONE_Q;
            default: return mvt_word_t'(int'($urandom_range(0, (2 << scale) - 1)) - (1 << scale));
        endcase
    endfunction

    task automatic add_transforms(input int count, input int scale);
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 1) != 0) ? OP_VEC4 : OP_POINT;
            add_cmd(op, 4'($urandom), mvt_word_t'($urandom), pick_word(scale),
                    pick_word(scale), pick_word(scale), pick_word(scale), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present pending items in bursts, predict on acceptance
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        logic nxt_valid;
        if (!rst_n)
        begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.opcode     <= OP_WRITE;
            cmd_ch.elem_index <= '0;
            cmd_ch.elem_value <= '0;
            cmd_ch.vec_x      <= '0;
            cmd_ch.vec_y      <= '0;
            cmd_ch.vec_z      <= '0;
            cmd_ch.vec_w      <= '0;
        end
        else
        begin
            // Item taken at this edge: update the shadow store or predict its result
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                case (cur_cmd.opcode)
                    OP_WRITE:
                    begin
                        matrix_shadow[cur_cmd.elem_index] = cur_cmd.elem_value;
                        n_writes++;
                    end
                    OP_VEC4:
                    begin
                        expected_vertices.push_back(transform_item(cur_cmd));
                        n_vec4++;
                    end
                    OP_POINT:
                    begin
                        expected_vertices.push_back(transform_item(cur_cmd));
                        n_point++;
                    end
                    default:
                        n_spare++;
                endcase
            end
            // Hold the current item while it waits for ready; otherwise advance
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                nxt_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain_first && expected_vertices.size() != 0))
                begin
                    cur_cmd   = pending_cmds.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                               : $urandom_range(0, 4);
                end
                cmd_ch.valid <= nxt_valid;
                if (nxt_valid)
                begin
                    cmd_ch.opcode     <= cur_cmd.opcode;
                    cmd_ch.elem_index <= cur_cmd.elem_index;
                    cmd_ch.elem_value <= cur_cmd.elem_value;
                    cmd_ch.vec_x      <= cur_cmd.vec_x;
                    cmd_ch.vec_y      <= cur_cmd.vec_y;
                    cmd_ch.vec_z      <= cur_cmd.vec_z;
                    cmd_ch.vec_w      <= cur_cmd.vec_w;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result items, drive ready on a changing stall pattern
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;

    task automatic compare_word(input string field, input mvt_word_t exp, input mvt_word_t act);
        if (exp !== act)
        begin
            $error("%s: expected %0d, got %0d", field, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : res_monitor
        vertex_res_t exp;
        logic        rdy;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $error("result item with no transform outstanding");
                    fail_count++;
                end
                else
                begin
                    exp = expected_vertices.pop_front();
                    compare_word("out_x", exp.x, res_ch.out_x);
                    compare_word("out_y", exp.y, res_ch.out_y);
                    compare_word("out_z", exp.z, res_ch.out_z);
                    compare_word("out_w", exp.w, res_ch.out_w);
                    compare_word("saturated", mvt_word_t'(exp.sat),
                                 mvt_word_t'(res_ch.saturated));
                    n_checked++;
                    if (exp.sat)
                        n_sat++;
                end
            end
            // Switch between free flow, light, toggling and heavy stalls
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                2:       rdy = ~res_ch.ready;
                default: rdy = ($urandom_range(0, 4) == 0);
            endcase
            res_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int target;
        int scale;
        int idx_order [ELEMS];
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = OP_WRITE;
        cmd_ch.elem_index = '0;
        cmd_ch.elem_value = '0;
        cmd_ch.vec_x      = '0;
        cmd_ch.vec_y      = '0;
        cmd_ch.vec_z      = '0;
        cmd_ch.vec_w      = '0;
        res_ch.ready      = 1'b0;

        // Shadow store starts as identity, as the core does after reset
        for (int i = 0; i < ELEMS; i++)
            matrix_shadow[i] = ((i % (LANES + 1)) == 0) ? ONE_Q : '0;

        // Directed: identity passes extremes straight through
        add_cmd(OP_VEC4, 4'd0, '0, ONE_Q, WORD_MIN, WORD_MAX, -ONE_Q, 1'b0);
        add_cmd(OP_POINT, 4'd0, '0, WORD_MAX, WORD_MIN, ONE_Q, WORD_MIN, 1'b0);
        // Unused opcode must not touch the store, even aimed at element 0
        add_cmd(OP_SPARE, 4'd0, '0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        add_cmd(OP_SPARE, 4'd15, WORD_MIN, '1, '1, '1, '1, 1'b0);
        add_cmd(OP_VEC4, 4'd0, '0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        // Positive saturation on lane 0
        add_cmd(OP_WRITE, 4'd0, WORD_MAX, '1, '1, '1, '1, 1'b0);
        add_cmd(OP_WRITE, 4'd4, WORD_MAX, '0, '0, '0, '0, 1'b0);
        add_cmd(OP_VEC4, 4'd15, WORD_MIN, WORD_MAX, WORD_MAX, '0, '0, 1'b0);
        // Negative saturation on lane 0
        add_cmd(OP_VEC4, 4'd0, '0, WORD_MIN, WORD_MIN, '0, '0, 1'b0);
        // Restore lane 0, then make lane 3 blow up
        add_cmd(OP_WRITE, 4'd0, ONE_Q, '0, '0, '0, '0, 1'b0);
        add_cmd(OP_WRITE, 4'd4, '0, '0, '0, '0, '0, 1'b0);
        add_cmd(OP_WRITE, 4'd3, WORD_MIN, '0, '0, '0, '0, 1'b0);
        add_cmd(OP_WRITE, 4'd7, WORD_MIN, '0, '0, '0, '0, 1'b0);
        add_cmd(OP_WRITE, 4'd15, WORD_MIN, '0, '0, '0, '0, 1'b0);
        // Point mode: lane 3 would clip but neither out_w nor the flag may show it
        add_cmd(OP_POINT, 4'd0, '0, WORD_MIN, WORD_MIN, '0, WORD_MAX, 1'b0);
        add_cmd(OP_VEC4, 4'd0, '0, WORD_MIN, WORD_MIN, '0, WORD_MAX, 1'b0);
        // Floor rounding of tiny products, both signs
        add_cmd(OP_WRITE, 4'd0, mvt_word_t'(1), '0, '0, '0, '0, 1'b0);
        add_cmd(OP_VEC4, 4'd0, '0, -mvt_word_t'(1), '0, '0, '0, 1'b0);
        add_cmd(OP_VEC4, 4'd0, '0, mvt_word_t'(1), '0, '0, '0, 1'b0);
        add_cmd(OP_POINT, 4'd0, '0, -mvt_word_t'(3), mvt_word_t'(7), -ONE_Q, '0, 1'b0);

        // Random: full matrix loads with transforms, partial updates, noise and drains
        target = live_items + RANDOM_ITEMS;
        add_cmd(OP_VEC4, 4'($urandom), mvt_word_t'($urandom), mvt_word_t'($urandom),
                mvt_word_t'($urandom), mvt_word_t'($urandom), mvt_word_t'($urandom), 1'b1);
        while (live_items < target)
        begin
            scale = $urandom_range(8, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // Full load in a shuffled order
                    for (int i = 0; i < ELEMS; i++)
                        idx_order[i] = i;
                    idx_order.shuffle();
                    for (int i = 0; i < ELEMS; i++)
                        add_cmd(OP_WRITE, 4'(idx_order[i]), pick_word(scale),
                                mvt_word_t'($urandom), mvt_word_t'($urandom),
                                mvt_word_t'($urandom), mvt_word_t'($urandom), 1'b0);
                    add_transforms($urandom_range(4, 20), scale);
                end
                4, 5:
                begin
                    // Partial update interleaved with transforms
                    for (int i = 0; i < $urandom_range(1, 5); i++)
                        add_cmd(OP_WRITE, 4'($urandom), pick_word(scale),
                                mvt_word_t'($urandom), mvt_word_t'($urandom),
                                mvt_word_t'($urandom), mvt_word_t'($urandom), 1'b0);
                    add_transforms($urandom_range(1, 8), scale);
                end
                6, 7, 8:
                begin
                    // Noise: any opcode, raw fields
                    for (int i = 0; i < $urandom_range(2, 10); i++)
                        add_cmd(2'($urandom), 4'($urandom), mvt_word_t'($urandom),
                                mvt_word_t'($urandom), mvt_word_t'($urandom),
                                mvt_word_t'($urandom), mvt_word_t'($urandom), 1'b0);
                end
                default:
                begin
                    // Wait for the pipeline to empty, then go again
                    add_cmd(OP_POINT, 4'($urandom), mvt_word_t'($urandom), pick_word(scale),
                            pick_word(scale), pick_word(scale), pick_word(scale), 1'b1);
                    add_transforms($urandom_range(1, 6), scale);
                end
            endcase
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_vertices.size() != 0)
        begin
            $error("%0d transform results never arrived", expected_vertices.size());
            fail_count++;
        end

        $display("Covered %0d element writes, %0d vector and %0d point transforms, %0d ignored",
                 n_writes, n_vec4, n_point, n_spare);
        $display("Checked %0d result items, %0d of them saturated", n_checked, n_sat);
        if (fail_count == 0)
            $display("PASS matrix_vector_transform_core");
        else
            $display("FAIL matrix_vector_transform_core");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL matrix_vector_transform_core");
        $finish;
    end

endmodule
